/* rtl/core/htep_pkg.sv */
// Shared types and constants for the table-driven Huffman encoder and packer.
// No dependencies.
`timescale 1ns / 1ps
package htep_pkg;

  localparam int MAX_CODE_LEN = 32;
  localparam int NUM_SYMBOLS  = 256;
  localparam int TABLE_DEPTH  = 256;
  localparam int CODE_W       = 32;
  localparam int LEN_W        = 6;
  localparam int SYM_W        = 8;
  localparam int BYTES_MAX    = 4;
  localparam int LEN_CAP      = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int ACC_W        = CODE_W + 7;

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_ENCODE = 2'd1,
    REQ_FLUSH  = 2'd2
  } req_e;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [SYM_W-1:0]  symbol;
    logic [LEN_W-1:0]  code_length;
    logic [CODE_W-1:0] code_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [LEN_W-1:0]  code_length;
    logic [CODE_W-1:0] code_value;
  } lookup_t;

endpackage

/* rtl/core/huffman_table_encoder_packer_unit.sv */
// Top level of the table-driven Huffman encoder with byte packer.
// Depends on htep_pkg and htep_code_store.
`timescale 1ns / 1ps
// Usage:
//   Input channel in_valid_i/in_ready_o carries in_item_i: a load writes one
//   code table entry, an encode appends a symbol's code to the bit buffer, a
//   flush releases the remaining 1 to 7 bits as one zero-padded byte.
//   Output channel out_valid_o/out_ready_i carries out_item_o, one packed
//   byte per transfer, last set on the final byte of an input item.
//   The first byte of an item is offered from the byte buffer: the table is
//   read at the accepting edge, and the item is packed into the byte buffer
//   once that buffer can take it.
//   An item is packed whole into the byte buffer, and the next item can be
//   looked up while its bytes drain. The four-entry byte buffer drains one byte
//   per cycle to out_item_o while out_ready_i is high; loads give no output.
//   Reset clears the bit buffer, the byte buffer and all table valid bits, so
//   every symbol reads as length zero; no clearing pass is needed.
//   When the receiver stalls, the byte buffer holds, one looked-up item waits
//   in the pack stage, and in_ready_o drops until the buffer can take it.
module huffman_table_encoder_packer_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  htep_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output htep_pkg::out_item_t out_item_o
);
  import htep_pkg::*;

  logic                 in_acc;
  logic                 sym_ok;
  logic                 is_load;
  logic                 is_enc;
  logic                 is_flush;
  logic                 enters;
  logic [LEN_W-1:0]     wr_len;
  logic [CODE_W:0]      wr_mask;
  lookup_t              wr_entry;
  lookup_t              rd_entry;

  logic                 s1_valid_q, s1_valid_d;
  logic                 s1_flush_q;
  logic [6:0]           pend_bits_q, pend_bits_d;
  logic [2:0]           pend_cnt_q, pend_cnt_d;
  logic [7:0]           buf_byte_q [BYTES_MAX];
  logic [7:0]           buf_byte_d [BYTES_MAX];
  logic [2:0]           buf_rem_q, buf_rem_d;
  logic [1:0]           buf_idx_q, buf_idx_d;
  logic                 buf_free;
  logic                 s1_adv;
  logic                 out_acc;

  logic [LEN_W-1:0]     total;
  logic [ACC_W-1:0]     acc;
  logic [7:0]           keep_mask;
  logic [7:0]           flush_byte;
  logic [LEN_W-1:0]     shamt [BYTES_MAX];

  assign in_acc   = in_valid_i && in_ready_o;
  assign sym_ok   = {1'b0, in_item_i.symbol} < 9'(NUM_SYMBOLS);
  assign is_load  = in_item_i.req_type == REQ_LOAD;
  assign is_enc   = in_item_i.req_type == REQ_ENCODE;
  assign is_flush = in_item_i.req_type == REQ_FLUSH;
  assign enters   = in_acc && (is_flush || (is_enc && sym_ok));

  assign wr_len = (in_item_i.code_length > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP)
                                                            : in_item_i.code_length;
  assign wr_mask = ((CODE_W+1)'(1) << wr_len) - (CODE_W+1)'(1);
  assign wr_entry.code_length = wr_len;
  assign wr_entry.code_value  = in_item_i.code_value & wr_mask[CODE_W-1:0];

  htep_code_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (in_acc && is_load && sym_ok),
    .rd_en_i    (in_acc && is_enc && sym_ok),
    .addr_i     (in_item_i.symbol),
    .wr_entry_i (wr_entry),
    .rd_entry_o (rd_entry)
  );

  assign buf_free   = (buf_rem_q == 3'd0) || ((buf_rem_q == 3'd1) && out_ready_i);
  assign s1_adv     = s1_valid_q && buf_free;
  assign in_ready_o = !s1_valid_q || buf_free;
  assign out_valid_o = buf_rem_q != 3'd0;
  assign out_acc     = out_valid_o && out_ready_i;

  assign total = LEN_W'(pend_cnt_q) + rd_entry.code_length;
  assign acc   = (ACC_W'(pend_bits_q) << rd_entry.code_length)
               | ACC_W'(rd_entry.code_value);
  assign keep_mask  = (8'd1 << total[2:0]) - 8'd1;
  assign flush_byte = {1'b0, pend_bits_q} << (4'd8 - {1'b0, pend_cnt_q});

  always_comb begin
    for (int k = 0; k < BYTES_MAX; k++) begin
      shamt[k] = total - LEN_W'(8 * (k + 1));
    end
  end

  always_comb begin
    s1_valid_d  = s1_valid_q;
    pend_bits_d = pend_bits_q;
    pend_cnt_d  = pend_cnt_q;
    buf_byte_d  = buf_byte_q;
    buf_rem_d   = buf_rem_q;
    buf_idx_d   = buf_idx_q;
    if (out_acc) begin
      buf_rem_d = buf_rem_q - 3'd1;
      buf_idx_d = buf_idx_q + 2'd1;
    end
    if (s1_adv) begin
      s1_valid_d = 1'b0;
      buf_idx_d  = '0;
      if (s1_flush_q) begin
        buf_byte_d[0] = flush_byte;
        buf_rem_d     = (pend_cnt_q != 3'd0) ? 3'd1 : 3'd0;
        pend_bits_d   = '0;
        pend_cnt_d    = '0;
      end else begin
        for (int k = 0; k < BYTES_MAX; k++) begin
          buf_byte_d[k] = 8'(acc >> shamt[k]);
        end
        buf_rem_d   = total[5:3];
        pend_bits_d = acc[6:0] & keep_mask[6:0];
        pend_cnt_d  = total[2:0];
      end
    end
    if (enters) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      pend_bits_q <= '0;
      pend_cnt_q  <= '0;
      buf_rem_q   <= '0;
      buf_idx_q   <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      pend_bits_q <= pend_bits_d;
      pend_cnt_q  <= pend_cnt_d;
      buf_rem_q   <= buf_rem_d;
      buf_idx_q   <= buf_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_byte_q <= buf_byte_d;
    if (enters) begin
      s1_flush_q <= is_flush;
    end
  end

  assign out_item_o.data_byte = buf_byte_q[buf_idx_q];
  assign out_item_o.last      = buf_rem_q == 3'd1;

endmodule

/* rtl/core/htep_code_store.sv */
// Code table storage: length and code memories with per-entry valid bits.
// Depends on htep_pkg.
`timescale 1ns / 1ps
module htep_code_store (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr_en_i,
  input  logic                       rd_en_i,
  input  logic [htep_pkg::SYM_W-1:0] addr_i,
  input  htep_pkg::lookup_t          wr_entry_i,
  output htep_pkg::lookup_t          rd_entry_o
);
  import htep_pkg::*;

  logic [LEN_W-1:0]       len_mem [TABLE_DEPTH];
  logic [CODE_W-1:0]      code_mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_q;
  logic                   rd_valid_q;
  logic [LEN_W-1:0]       rd_len_q;
  logic [CODE_W-1:0]      rd_code_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      len_mem[addr_i]  <= wr_entry_i.code_length;
      code_mem[addr_i] <= wr_entry_i.code_value;
    end
    if (rd_en_i) begin
      rd_len_q  <= len_mem[addr_i];
      rd_code_q <= code_mem[addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[addr_i];
      end
    end
  end

  assign rd_entry_o.code_length = rd_valid_q ? rd_len_q : '0;
  assign rd_entry_o.code_value  = rd_valid_q ? rd_code_q : '0;

endmodule

/* rtl/core/htep_checker.sv */
// Port-level checks for huffman_table_encoder_packer_unit, bound to the top.
// Depends on htep_pkg.
`timescale 1ns / 1ps
module htep_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input htep_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input htep_pkg::out_item_t out_item_o
);
  import htep_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("output item changed or dropped while stalled");

  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no output pending");

  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_item_o.last |=> out_valid_o)
    else $error("gap inside the bytes of one item");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o && in_ready_o)
    else $error("block not idle after reset");

endmodule

bind huffman_table_encoder_packer_unit htep_checker u_htep_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

/* verif/tb_huffman_table_encoder_packer_unit.sv */
// Self-checking testbench for huffman_table_encoder_packer_unit: loads, encodes and flushes
// with random gaps on both channels, bytes checked against an in-bench bit packer.
// Depends on htep_pkg and the RTL of huffman_table_encoder_packer_unit.
`timescale 1ns / 1ps
module tb_huffman_table_encoder_packer_unit;
  import htep_pkg::*;

  localparam logic [1:0] REQ_UNUSED   = 2'd3;
  localparam int         IDLE_LIMIT   = 2000;
  localparam int         RANDOM_ITEMS = 385;

  logic      clk       = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  huffman_table_encoder_packer_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  always #5 clk = ~clk;

  logic [LEN_W-1:0]  code_len_tab  [TABLE_DEPTH];
  logic [CODE_W-1:0] code_bits_tab [TABLE_DEPTH];
  logic [6:0]        bit_buf;
  logic [2:0]        bit_cnt;

  in_item_t  pending_reqs   [$];
  out_item_t expected_bytes [$];
  bit        loaded [TABLE_DEPTH];
  int        pushed;
  int        errors = 0;
  int        in_gap, in_burst, out_stall, out_burst;
  int        idle_cycles = 0;

  task automatic report(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic pack_code_bits(input in_item_t it);
    int        len;
    int        total;
    int        sh;
    logic [63:0] acc;
    logic [63:0] shifted;
    out_item_t r;
    case (it.req_type)
      REQ_LOAD: begin
        len = int'(it.code_length);
        if (len > LEN_CAP) len = LEN_CAP;
        acc = {32'd0, it.code_value};
        if (len < CODE_W) acc = acc & ((64'd1 << len) - 64'd1);
        code_len_tab[it.symbol]  = len[LEN_W-1:0];
        code_bits_tab[it.symbol] = acc[CODE_W-1:0];
      end
      REQ_ENCODE: begin
        len = int'(code_len_tab[it.symbol]);
        if (len != 0) begin
          acc   = ({57'd0, bit_buf} << len) | {32'd0, code_bits_tab[it.symbol]};
          total = int'(bit_cnt) + len;
          while (total >= 8) begin
            shifted     = acc >> (total - 8);
            r.data_byte = shifted[7:0];
            total       = total - 8;
            r.last      = (total < 8);
            expected_bytes = {expected_bytes, r};
          end
          acc     = acc & ((64'd1 << total) - 64'd1);
          bit_buf = acc[6:0];
          bit_cnt = total[2:0];
        end
      end
      REQ_FLUSH: begin
        if (bit_cnt != 3'd0) begin
          sh          = 8 - int'(bit_cnt);
          r.data_byte = {1'b0, bit_buf} << sh;
          r.last      = 1'b1;
          expected_bytes = {expected_bytes, r};
          bit_buf = '0;
          bit_cnt = '0;
        end
      end
      default: ;
    endcase
  endtask

  function automatic int pick_gap(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk or negedge rst_ni) begin : driver
    logic     nxt_valid;
    in_item_t nxt_item;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_item  <= '0;
      in_gap   = 0;
      in_burst = 0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        code_len_tab[i]  = '0;
        code_bits_tab[i] = '0;
      end
      bit_buf = '0;
      bit_cnt = '0;
    end else begin
      nxt_valid = in_valid;
      nxt_item  = in_item;
      if (in_valid && in_ready) begin
        pack_code_bits(in_item);
        nxt_valid = 1'b0;
        in_gap    = pick_gap(in_burst);
      end
      if (!nxt_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_reqs.size() != 0) begin
          nxt_item  = pending_reqs.pop_front();
          nxt_valid = 1'b1;
        end
      end
      in_valid <= nxt_valid;
      in_item  <= nxt_item;
    end
  end

  always @(posedge clk or negedge rst_ni) begin : monitor
    out_item_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      out_stall = 0;
      out_burst = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          report($sformatf("unexpected byte %02h last %0b", out_item.data_byte, out_item.last));
        end else begin
          want = expected_bytes.pop_front();
          if (out_item.data_byte !== want.data_byte)
            report($sformatf("data_byte %02h, want %02h", out_item.data_byte, want.data_byte));
          if (out_item.last !== want.last)
            report($sformatf("last %0b, want %0b", out_item.last, want.last));
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < 15) begin
        out_stall = pick_gap(out_burst);
        out_ready <= (out_stall == 0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_huffman_table_encoder_packer_unit failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_item(input logic [1:0] req, input int sym, input int len,
                           input logic [31:0] val);
    in_item_t it;
    it.req_type    = req;
    it.symbol      = sym[SYM_W-1:0];
    it.code_length = len[LEN_W-1:0];
    it.code_value  = val;
    pending_reqs = {pending_reqs, it};
    if (req == REQ_LOAD) loaded[sym] = 1'b1;
    pushed++;
  endtask

  function automatic int random_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return 0;
    if (r < 70) return $urandom_range(1, 12);
    if (r < 90) return $urandom_range(13, 32);
    return $urandom_range(33, 63);
  endfunction

  task automatic drain();
    while (pending_reqs.size() != 0 || in_valid || expected_bytes.size() != 0)
      @(posedge clk);
  endtask

  initial begin : stimulus
    int  r;
    int  sym;
    int  total_items;
    bit  paused;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      loaded[i] = 1'b0;
    end
    pushed      = 0;
    paused      = 1'b0;
    repeat (8) @(posedge clk);
    rst_ni <= 1'b1;

    push_item(REQ_LOAD,   0,   0,  32'hFFFF_FFFF);
    push_item(REQ_ENCODE, 0,   0,  32'h0);
    push_item(REQ_FLUSH,  0,   0,  32'h0);
    push_item(REQ_LOAD,   255, 32, 32'hFFFF_FFFF);
    push_item(REQ_LOAD,   1,   1,  32'hFFFF_FFFF);
    push_item(REQ_LOAD,   2,   63, 32'hA5A5_0F0F);
    push_item(REQ_LOAD,   3,   33, 32'h0000_0001);
    push_item(REQ_LOAD,   4,   7,  32'hFFFF_FF00);
    push_item(REQ_LOAD,   128, 8,  32'h0000_005A);
    push_item(REQ_ENCODE, 255, 0,  32'h0);
    push_item(REQ_ENCODE, 1,   0,  32'h0);
    push_item(REQ_ENCODE, 2,   0,  32'h0);
    push_item(REQ_FLUSH,  0,   0,  32'h0);
    push_item(REQ_ENCODE, 4,   0,  32'h0);
    push_item(REQ_ENCODE, 1,   0,  32'h0);
    push_item(REQ_ENCODE, 3,   0,  32'h0);
    push_item(REQ_ENCODE, 128, 0,  32'h0);
    push_item(REQ_UNUSED, 255, 63, 32'hFFFF_FFFF);
    push_item(REQ_FLUSH,  0,   0,  32'h0);
    push_item(REQ_LOAD,   5,   3,  32'h0000_0005);
    push_item(REQ_ENCODE, 5,   0,  32'h0);
    push_item(REQ_FLUSH,  0,   0,  32'h0);
    push_item(REQ_LOAD,   255, 0,  32'h0);
    push_item(REQ_ENCODE, 255, 0,  32'h0);

    total_items = pushed + RANDOM_ITEMS;
    while (pushed < total_items) begin
      if (!paused && pushed >= total_items / 2) begin
        paused = 1'b1;
        drain();
      end
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 70) sym = $urandom_range(0, 15);
      else sym = $urandom_range(0, TABLE_DEPTH - 1);
      if (r < 62) begin
        if (!loaded[sym]) push_item(REQ_LOAD, sym, random_length(), $urandom);
        push_item(REQ_ENCODE, sym, $urandom_range(0, 63), $urandom);
      end else if (r < 82) begin
        push_item(REQ_LOAD, sym, random_length(), $urandom);
      end else if (r < 95) begin
        push_item(REQ_FLUSH, sym, $urandom_range(0, 63), $urandom);
      end else begin
        push_item(REQ_UNUSED, sym, $urandom_range(0, 63), $urandom);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0 && expected_bytes.size() == 0) begin
      $display("tb_huffman_table_encoder_packer_unit passed");
    end else begin
      $display("tb_huffman_table_encoder_packer_unit failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/htep_pkg.sv
rtl/core/htep_code_store.sv
rtl/core/huffman_table_encoder_packer_unit.sv
rtl/core/htep_checker.sv
verif/tb_huffman_table_encoder_packer_unit.sv
